// ===== rtl/dsl_pkg.sv =====
// Shared types, constants and the line style decode for the styled line rasterizer.
// No dependencies.
package dsl_pkg;

  localparam int DSL_COORD_BITS = 10;
  localparam int DSL_FRAC_BITS  = 16;

  localparam int PHASE_BITS  = 4;
  localparam int PATTERN_LEN = 9;

  localparam logic [1:0] STYLE_SOLID    = 2'd0;
  localparam logic [1:0] STYLE_DOTTED   = 2'd1;
  localparam logic [1:0] STYLE_DASHED   = 2'd2;
  localparam logic [1:0] STYLE_DASH_DOT = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef struct packed {
    logic load;
    logic div_en;
    logic step;
  } dsl_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic div_last;
    logic active;
  } dsl_sts_t;

  function automatic logic style_plots(input logic [1:0] style,
                                       input logic [PHASE_BITS-1:0] phase,
                                       input logic odd);
    logic p;
    begin
      case (style)
        STYLE_SOLID:    p = 1'b1;
        STYLE_DOTTED:   p = odd;
        STYLE_DASHED:   p = (phase <= PHASE_BITS'(4));
        STYLE_DASH_DOT: p = ((phase >= PHASE_BITS'(2)) && (phase <= PHASE_BITS'(6)))
                            || (phase == PHASE_BITS'(8));
        default:        p = 1'b1;
      endcase
      return p;
    end
  endfunction

endpackage

// ===== rtl/dsl_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle: (mag << FRAC_BITS) / len.
// Requires mag <= len. Quotient bits advance only while en_i is high. Depends on dsl_pkg.
module dsl_div #(
  parameter int COORD_BITS = dsl_pkg::DSL_COORD_BITS,
  parameter int FRAC_BITS  = dsl_pkg::DSL_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic                  en_i,
  input  logic [COORD_BITS-1:0] mag_i,
  input  logic [COORD_BITS-1:0] len_i,
  output logic [FRAC_BITS:0]    quo_o
);
  import dsl_pkg::*;

  logic [COORD_BITS:0]   rem_q, rem_d;
  logic [FRAC_BITS:0]    quo_q, quo_d;
  logic [COORD_BITS+1:0] diff;
  logic                  ge;
  logic [COORD_BITS:0]   kept;

  always_comb begin
    diff = {1'b0, rem_q} - {2'b00, len_i};
    ge   = ~diff[COORD_BITS+1];
    kept = ge ? diff[COORD_BITS:0] : rem_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (load_i) begin
      rem_d = {1'b0, mag_i};
    end else if (en_i) begin
      rem_d = {kept[COORD_BITS-1:0], 1'b0};
      quo_d = {quo_q[FRAC_BITS-1:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

// ===== rtl/dsl_dp.sv =====
// Datapath: setup of length and deltas, two increment dividers, position
// accumulators, style phase and the output payload register. Depends on dsl_pkg, dsl_div.
module dsl_dp #(
  parameter int COORD_BITS = dsl_pkg::DSL_COORD_BITS,
  parameter int FRAC_BITS  = dsl_pkg::DSL_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dsl_pkg::dsl_cmd_t     cmd_i,
  output dsl_pkg::dsl_sts_t     sts_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [1:0]            line_style_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  plot_o,
  output logic                  last_o
);
  import dsl_pkg::*;

  localparam int POS_BITS = COORD_BITS + FRAC_BITS + 1;
  localparam int CNT_W    = $clog2(FRAC_BITS + 1);
  localparam int EXT_W    = POS_BITS - FRAC_BITS - 1;

  logic [COORD_BITS-1:0] adx, ady, len;
  logic                  negx, negy;

  logic [COORD_BITS-1:0] len_q, steps_q, steps_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  negx_q, negy_q;
  logic [POS_BITS-1:0]   pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [POS_BITS-1:0]   add_x, add_y;
  logic                  odd_q, odd_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [1:0]            style_q;
  logic [FRAC_BITS:0]    quo_x, quo_y;

  logic [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
  logic                  plot_q, last_q;

  always_comb begin
    negx = end_x_i < start_x_i;
    negy = end_y_i < start_y_i;
    adx  = negx ? start_x_i - end_x_i : end_x_i - start_x_i;
    ady  = negy ? start_y_i - end_y_i : end_y_i - start_y_i;
    len  = (adx > ady) ? adx : ady;
  end

  dsl_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .en_i   (cmd_i.div_en),
    .mag_i  (adx),
    .len_i  (len_q),
    .quo_o  (quo_x)
  );

  dsl_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .en_i   (cmd_i.div_en),
    .mag_i  (ady),
    .len_i  (len_q),
    .quo_o  (quo_y)
  );

  // signed increment applied as add of the one's complement plus carry-in
  assign add_x = negx_q ? ~{{EXT_W{1'b0}}, quo_x} : {{EXT_W{1'b0}}, quo_x};
  assign add_y = negy_q ? ~{{EXT_W{1'b0}}, quo_y} : {{EXT_W{1'b0}}, quo_y};

  always_comb begin
    steps_d = steps_q;
    cnt_d   = cnt_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    odd_d   = odd_q;
    phase_d = phase_q;
    if (cmd_i.load) begin
      steps_d = len;
      cnt_d   = CNT_W'(FRAC_BITS);
      pos_x_d = {1'b0, start_x_i, 1'b1, {(FRAC_BITS-1){1'b0}}};
      pos_y_d = {1'b0, start_y_i, 1'b1, {(FRAC_BITS-1){1'b0}}};
      odd_d   = 1'b0;
      phase_d = '0;
    end else begin
      if (cmd_i.div_en) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
      if (cmd_i.step) begin
        steps_d = steps_q - COORD_BITS'(1);
        pos_x_d = pos_x_q + add_x + POS_BITS'(negx_q);
        pos_y_d = pos_y_q + add_y + POS_BITS'(negy_q);
        odd_d   = ~odd_q;
        phase_d = (phase_q == PHASE_BITS'(PATTERN_LEN - 1)) ? '0 : phase_q + PHASE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      cnt_q   <= '0;
      odd_q   <= 1'b0;
      phase_q <= '0;
      style_q <= STYLE_SOLID;
    end else begin
      steps_q <= steps_d;
      cnt_q   <= cnt_d;
      odd_q   <= odd_d;
      phase_q <= phase_d;
      if (cmd_i.load) begin
        style_q <= line_style_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q <= pos_x_d;
    pos_y_q <= pos_y_d;
    if (cmd_i.load) begin
      len_q  <= len;
      negx_q <= negx;
      negy_q <= negy;
    end
    if (cmd_i.step) begin
      pixel_x_q <= pos_x_q[FRAC_BITS +: COORD_BITS];
      pixel_y_q <= pos_y_q[FRAC_BITS +: COORD_BITS];
      plot_q    <= style_plots(style_q, phase_q, odd_q);
      last_q    <= (steps_q == COORD_BITS'(1));
    end
  end

  assign sts_o.len_zero = (len == '0);
  assign sts_o.div_last = (cnt_q == '0);
  assign sts_o.active   = (steps_q != '0);

  assign pixel_x_o = pixel_x_q;
  assign pixel_y_o = pixel_y_q;
  assign plot_o    = plot_q;
  assign last_o    = last_q;

endmodule

// ===== rtl/dsl_ctrl.sv =====
// Controller: input/output handshake, load and step decode, divide sequencing.
// Depends on dsl_pkg.
module dsl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  dsl_pkg::dsl_sts_t sts_i,
  output dsl_pkg::dsl_cmd_t cmd_o,
  output logic              busy_o
);
  import dsl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_hold, accept;

  always_comb begin
    out_hold     = out_valid_q & out_stall_i;
    in_stall_o   = (state_q == ST_DIV) | out_hold;
    accept       = in_valid_i & ~in_stall_o;
    cmd_o.load   = accept & (mode_i == MODE_LOAD);
    cmd_o.step   = accept & (mode_i == MODE_STEP) & sts_i.active;
    cmd_o.div_en = (state_q == ST_DIV);
    out_valid_d  = cmd_o.step | out_hold;
    state_d      = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load && !sts_i.len_zero) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign busy_o      = (state_q == ST_DIV);

endmodule

// ===== rtl/dda_styled_line_rasterizer.sv =====
// DDA line rasterizer with solid, dotted, dashed and dash-dot styles.
// Load item: after accept, serial division (one quotient bit per cycle in both
// axis dividers) runs with in_stall_o high; a zero-length line skips the division.
// Step item: registered the cycle after accept; one pixel per cycle unless stalled.
// Reset (rst_ni low, async) leaves no line active and the output register empty.
module dda_styled_line_rasterizer #(
  parameter int COORD_BITS = dsl_pkg::DSL_COORD_BITS,
  parameter int FRAC_BITS  = dsl_pkg::DSL_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [1:0]            line_style_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  plot_o,
  output logic                  last_o
);
  import dsl_pkg::*;

  dsl_cmd_t cmd;
  dsl_sts_t sts;
  logic     busy;

  dsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  dsl_dp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .line_style_i (line_style_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .plot_o       (plot_o),
    .last_o       (last_o)
  );

  a_div_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("item accepted during divide");

  a_step_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> sts.active && !busy)
    else $error("step issued with no line active");

  a_step_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |=> out_valid_o)
    else $error("step result not presented");

  a_load_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && !sts.len_zero |=> busy)
    else $error("nonzero line load did not start divide");

endmodule
